// File: sv/skmj_pkg.sv
// ============================================================================
// skmj_pkg: shared types and constants for the sorted key merge join
// Table geometry, command codes and the request and response transaction
// layouts used on the ports of the join block.
// ============================================================================
package skmj_pkg;

   // Table geometry.
   localparam int TABLE_DEPTH = 65536;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = ADDR_W + 1;
   localparam int WORD_W      = 32;
   localparam int KEY_W       = 64;

   // Command codes.
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // Request transaction: a table load or a query key.
   typedef struct packed {
      logic                    command;
      logic                    first_entry;
      logic signed [KEY_W-1:0] key;
      logic [WORD_W-1:0]       pos_x;
      logic [WORD_W-1:0]       pos_y;
      logic [WORD_W-1:0]       pos_z;
      logic [WORD_W-1:0]       vel_x;
      logic [WORD_W-1:0]       vel_y;
      logic [WORD_W-1:0]       vel_z;
   } req_type;

   // Response transaction: one per query.
   typedef struct packed {
      logic              found;
      logic              exhausted;
      logic [WORD_W-1:0] out_pos_x;
      logic [WORD_W-1:0] out_pos_y;
      logic [WORD_W-1:0] out_pos_z;
      logic [WORD_W-1:0] out_vel_x;
      logic [WORD_W-1:0] out_vel_y;
      logic [WORD_W-1:0] out_vel_z;
      logic [WORD_W-1:0] match_count;
   } rsp_type;

   // One stored table row: key and six payload words.
   typedef struct packed {
      logic signed [KEY_W-1:0] key;
      logic [WORD_W-1:0]       pos_x;
      logic [WORD_W-1:0]       pos_y;
      logic [WORD_W-1:0]       pos_z;
      logic [WORD_W-1:0]       vel_x;
      logic [WORD_W-1:0]       vel_y;
      logic [WORD_W-1:0]       vel_z;
   } entry_type;

endpackage

// File: sv/sorted_key_merge_join.sv
// ============================================================================
// sorted_key_merge_join: merge join of a stored sorted table and query keys
// Loads append rows to a table held in one synchronous memory; queries walk
// a scan pointer forward through that memory and report the matching row.
//
//   Channel   Direction  Handshake              Transaction
//   req_      in         req_valid/req_ready    load row or query key
//   rsp_      out        rsp_valid/rsp_ready    one result per query
//
// A query steps the scan pointer over each stored entry that it skips, one
// memory read per step. A query on an exhausted scan reads no memory.
// Reset is synchronous and needs no clearing pass; table rows are only read
// below the fill count. A full response register holds a finished query in
// its last state; stored keys below the query key are still stepped over.
// ============================================================================
module sorted_key_merge_join (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  skmj_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output skmj_pkg::rsp_type rsp_data
);
   import skmj_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_COMPARE,
      S_EXHAUST
   } state_type;

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]        ptr_ff, ptr_in;
   logic [WORD_W-1:0]       match_ff, match_in;
   logic                    done_ff, done_in;
   logic signed [KEY_W-1:0] qkey_ff, qkey_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   // Table memory and its port controls.
   entry_type               entry_mem [TABLE_DEPTH];
   entry_type               rd_entry_ff;
   entry_type               wr_entry;
   logic                    rd_en, wr_en;
   logic [ADDR_W-1:0]       rd_addr, wr_addr;

   logic [CNT_W-1:0]        ptr_inc;
   logic [CNT_W-1:0]        load_base;
   logic                    out_free;
   logic                    key_lt, key_eq;

   // Helper terms for the scan step and the load slot.
   assign ptr_inc   = ptr_ff + CNT_W'(1);
   assign load_base = req_data.first_entry ? '0 : count_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign key_lt    = $signed(rd_entry_ff.key) < $signed(qkey_ff);
   assign key_eq    = rd_entry_ff.key == qkey_ff;

   assign wr_entry.key   = req_data.key;
   assign wr_entry.pos_x = req_data.pos_x;
   assign wr_entry.pos_y = req_data.pos_y;
   assign wr_entry.pos_z = req_data.pos_z;
   assign wr_entry.vel_x = req_data.vel_x;
   assign wr_entry.vel_y = req_data.vel_y;
   assign wr_entry.vel_z = req_data.vel_z;

   // Next-state logic for the loader and the scan sequencer.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      match_in     = match_ff;
      done_in      = done_ff;
      qkey_in      = qkey_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      rd_en        = 1'b0;
      rd_addr      = ptr_ff[ADDR_W-1:0];
      wr_en        = 1'b0;
      wr_addr      = load_base[ADDR_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_data.command == CMD_LOAD) begin
                  // A first row restarts the table and the scan.
                  if (req_data.first_entry) begin
                     count_in = '0;
                     ptr_in   = '0;
                     match_in = '0;
                     done_in  = 1'b0;
                  end
                  if (load_base < CNT_W'(TABLE_DEPTH)) begin
                     wr_en    = 1'b1;
                     count_in = load_base + CNT_W'(1);
                  end
               end else begin
                  qkey_in = req_data.key;
                  if (done_ff || ptr_ff >= count_ff) begin
                     done_in  = 1'b1;
                     state_in = S_EXHAUST;
                  end else begin
                     rd_en    = 1'b1;
                     state_in = S_COMPARE;
                  end
               end
            end
         end
         S_COMPARE: begin
            if (key_lt) begin
               // Stored key is smaller: step to the next row.
               ptr_in = ptr_inc;
               if (ptr_inc >= count_ff) begin
                  done_in  = 1'b1;
                  state_in = S_EXHAUST;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = ptr_inc[ADDR_W-1:0];
               end
            end else if (out_free) begin
               // Match or overshoot ends the query.
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               if (key_eq) begin
                  match_in              = (match_ff == '1) ? match_ff
                                                           : match_ff + WORD_W'(1);
                  rsp_data_in.found     = 1'b1;
                  rsp_data_in.out_pos_x = rd_entry_ff.pos_x;
                  rsp_data_in.out_pos_y = rd_entry_ff.pos_y;
                  rsp_data_in.out_pos_z = rd_entry_ff.pos_z;
                  rsp_data_in.out_vel_x = rd_entry_ff.vel_x;
                  rsp_data_in.out_vel_y = rd_entry_ff.vel_y;
                  rsp_data_in.out_vel_z = rd_entry_ff.vel_z;
               end
               rsp_data_in.match_count = match_in;
               state_in                = S_IDLE;
            end
         end
         S_EXHAUST: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in             = '0;
               rsp_data_in.exhausted   = 1'b1;
               rsp_data_in.match_count = match_ff;
               state_in                = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State, counters and the response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         ptr_ff       <= '0;
         match_ff     <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ptr_ff       <= ptr_in;
         match_ff     <= match_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      qkey_ff     <= qkey_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Table memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_entry;
      end
      if (rd_en) begin
         rd_entry_ff <= entry_mem[rd_addr];
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // The scan pointer never runs beyond the filled part of the table.
   a_ptr_in_range: assert property (@(posedge clock) disable iff (reset)
      ptr_ff <= count_ff)
      else $error("scan pointer beyond fill count");

   // A memory compare only happens on a live scan.
   a_compare_live: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_COMPARE |-> !done_ff)
      else $error("compare on an exhausted scan");

   // A response only appears after the sequencer has left idle.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) != S_IDLE)
      else $error("response raised from idle");
`endif

endmodule

// File: tb/testbench.sv
// ============================================================================
// testbench: self-checking bench for sorted_key_merge_join
// Drives table loads and mostly ascending query keys through the request channel
// and checks every response against a cycle-free prediction of the merge join.
// Directed tests cover the empty table, the extreme keys, repeated and out of
// order keys, and loads during and after a scan. Random tests then load small
// sorted tables and query them.
// ============================================================================
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import skmj_pkg::*;

   localparam longint KEY_MIN = longint'(64'h8000_0000_0000_0000);
   localparam longint KEY_MAX = longint'(64'h7FFF_FFFF_FFFF_FFFF);

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Idling on both channels is enabled while this flag is set.
   bit      idle_on = 1'b1;
   int      mismatches = 0;
   int      items_sent = 0;

   // Expected responses, oldest first.
   rsp_type pending_results[$];

   // Mirror of the join state.
   entry_type   rows[TABLE_DEPTH];
   int unsigned row_count = 0;
   int unsigned scan_idx = 0;
   logic [31:0] hit_count = '0;
   bit          scan_past_end = 1'b0;

   sorted_key_merge_join DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Run limit, far above the slowest legal run.
   initial begin
      #50ms;
      $display("** sorted_key_merge_join: FAILED **");
      $finish;
   end

   // Append a row to the mirrored table; a first entry restarts the table.
   function automatic void table_append(req_type it);
      if (it.first_entry) begin
         row_count     = 0;
         scan_idx      = 0;
         hit_count     = '0;
         scan_past_end = 1'b0;
      end
      if (row_count >= TABLE_DEPTH) return;
      rows[row_count] = '{key: it.key, pos_x: it.pos_x, pos_y: it.pos_y, pos_z: it.pos_z,
                          vel_x: it.vel_x, vel_y: it.vel_y, vel_z: it.vel_z};
      row_count++;
   endfunction

   // Advance the scan for one query key and build the response it yields.
   function automatic rsp_type lookup_key(logic signed [63:0] q);
      rsp_type r;
      r = '0;
      if (!scan_past_end) begin
         while (scan_idx < row_count && $signed(rows[scan_idx].key) < q) scan_idx++;
         if (scan_idx >= row_count) scan_past_end = 1'b1;
      end
      if (scan_past_end) begin
         r.exhausted = 1'b1;
      end else if ($signed(rows[scan_idx].key) == q) begin
         r.found     = 1'b1;
         r.out_pos_x = rows[scan_idx].pos_x;
         r.out_pos_y = rows[scan_idx].pos_y;
         r.out_pos_z = rows[scan_idx].pos_z;
         r.out_vel_x = rows[scan_idx].vel_x;
         r.out_vel_y = rows[scan_idx].vel_y;
         r.out_vel_z = rows[scan_idx].vel_z;
         if (hit_count != 32'hFFFF_FFFF) hit_count++;
      end
      r.match_count = hit_count;
      return r;
   endfunction

   function automatic longint rand_key();
      return longint'({$urandom(), $urandom()});
   endfunction

   // Payload words lean toward all zeros and all ones now and then.
   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 7))
         0: begin
            return '0;
         end
         1: begin
            return '1;
         end
         default: begin
            return $urandom();
         end
      endcase
   endfunction

   function automatic req_type load_item(bit first, longint k);
      req_type it;
      it.command     = CMD_LOAD;
      it.first_entry = first;
      it.key         = k;
      it.pos_x       = rand_word();
      it.pos_y       = rand_word();
      it.pos_z       = rand_word();
      it.vel_x       = rand_word();
      it.vel_y       = rand_word();
      it.vel_z       = rand_word();
      return it;
   endfunction

   // Query payload and first-entry bit are don't-care, so they are randomized.
   function automatic req_type query_item(longint k);
      req_type it;
      it             = load_item(1'($urandom_range(0, 1)), k);
      it.command     = CMD_QUERY;
      return it;
   endfunction

   task automatic report_mismatch(string msg);
      mismatches++;
      if (mismatches <= 40) $display("ERROR at %0t ns: %s", $time, msg);
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report_mismatch($sformatf("%s is %h, expected %h", name, got, want));
   endtask

   // Send one request transaction and update the prediction when it is taken.
   task automatic send_item(req_type it);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (req_ready !== 1'b1);
      items_sent++;
      if (it.command == CMD_QUERY) pending_results.push_back(lookup_key(it.key));
      else table_append(it);
   endtask

   // Hold off the sender until every expected response has come back.
   task automatic wait_results_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   // Response side: random stall bursts while idling is enabled.
   initial begin
      forever begin
         @(posedge clock);
         if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // Compare each response transaction with the oldest expectation.
   rsp_type want;
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (pending_results.size() == 0) begin
            report_mismatch("response with no query outstanding");
         end else begin
            want = pending_results.pop_front();
            check_field("found", 32'(rsp_data.found), 32'(want.found));
            check_field("exhausted", 32'(rsp_data.exhausted), 32'(want.exhausted));
            check_field("out_pos_x", rsp_data.out_pos_x, want.out_pos_x);
            check_field("out_pos_y", rsp_data.out_pos_y, want.out_pos_y);
            check_field("out_pos_z", rsp_data.out_pos_z, want.out_pos_z);
            check_field("out_vel_x", rsp_data.out_vel_x, want.out_vel_x);
            check_field("out_vel_y", rsp_data.out_vel_y, want.out_vel_y);
            check_field("out_vel_z", rsp_data.out_vel_z, want.out_vel_z);
            check_field("match_count", rsp_data.match_count, want.match_count);
         end
      end
   end

   // Queries straight after reset see an empty table and must exhaust.
   task automatic test_empty_table();
      send_item(query_item(KEY_MIN));
      send_item(query_item(KEY_MAX));
   endtask

   // Extreme keys, duplicates, out of order keys and loads around a scan.
   task automatic test_join_special_cases();
      send_item(load_item(1'b1, KEY_MIN));
      send_item(load_item(1'b0, -1));
      send_item(load_item(1'b0, 0));
      send_item(load_item(1'b0, 100));
      send_item(load_item(1'b0, 100));
      send_item(load_item(1'b0, KEY_MAX));
      send_item(query_item(KEY_MIN));
      send_item(query_item(KEY_MIN));
      send_item(query_item(-5));
      send_item(query_item(0));
      send_item(query_item(-1));
      send_item(query_item(100));
      send_item(query_item(100));
      send_item(query_item(KEY_MAX));
      // Exhaust, then append without a restart: the scan must stay exhausted.
      send_item(load_item(1'b1, 10));
      send_item(query_item(20));
      send_item(load_item(1'b0, 30));
      send_item(query_item(30));
      // Append while a scan is live: the scan reaches the new row.
      send_item(load_item(1'b1, 40));
      send_item(query_item(40));
      send_item(load_item(1'b0, 60));
      send_item(query_item(60));
      wait_results_drained();
   endtask

   // Small sorted tables with mostly sorted queries, plus broken sequences.
   task automatic test_random_joins(int budget);
      longint stored[$];
      longint probes[$];
      longint base, tmp;
      int     n, m, pick;
      int     quiet_from;
      quiet_from = items_sent + (budget * 85) / 100;
      budget     = items_sent + budget;
      while (items_sent < budget) begin
         idle_on = (items_sent < quiet_from) && ($urandom_range(0, 3) != 0);
         stored.delete();
         probes.delete();
         n    = $urandom_range(1, 24);
         base = rand_key();
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 2) == 0) stored.push_back(rand_key());
            else stored.push_back(base + $urandom_range(0, 40));
         end
         if ($urandom_range(0, 9) == 0) stored.push_back(KEY_MIN);
         if ($urandom_range(0, 9) == 0) stored.push_back(KEY_MAX);
         stored.sort();
         foreach (stored[i]) send_item(load_item(i == 0, stored[i]));

         m = $urandom_range(1, 30);
         for (int j = 0; j < m; j++) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) probes.push_back(stored[$urandom_range(0, stored.size() - 1)]);
            else if (pick < 9) probes.push_back(base + $urandom_range(0, 48));
            else probes.push_back(rand_key());
         end
         probes.sort();
         // Occasionally break the ascending order of the queries.
         if (m > 1 && $urandom_range(0, 7) == 0) begin
            pick              = $urandom_range(0, m - 2);
            tmp               = probes[pick];
            probes[pick]      = probes[pick + 1];
            probes[pick + 1]  = tmp;
         end
         foreach (probes[j]) begin
            if ($urandom_range(0, 11) == 0) begin
               stored.push_back(stored[$] + $urandom_range(0, 8));
               send_item(load_item(1'b0, stored[$]));
            end
            send_item(query_item(probes[j]));
         end
         if ($urandom_range(0, 4) == 0) wait_results_drained();
      end
      idle_on = 1'b0;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_empty_table();
      test_join_special_cases();
      test_random_joins(1930);
      wait_results_drained();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("** sorted_key_merge_join: PASSED **");
      end else begin
         $display("** sorted_key_merge_join: FAILED **");
      end
      $finish;
   end

endmodule

// File: sim.f
sv/skmj_pkg.sv
sv/sorted_key_merge_join.sv
tb/testbench.sv
